// ----- rtl/core/cdba_pkg.sv -----
// Shared types, codes and constants for the dilated 1D convolution block.
package cdba_pkg;

    // Request actions carried on the input channel.
    typedef enum logic [1:0] {
        ACT_LOAD_WEIGHT = 2'd0,
        ACT_LOAD_BIAS   = 2'd1,
        ACT_LOAD_SAMPLE = 2'd2,
        ACT_COMPUTE     = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_IN_CHANNELS  = 3'd0,
        CFG_OUT_CHANNELS = 3'd1,
        CFG_KERNEL_WIDTH = 3'd2,
        CFG_STRIDE       = 3'd3,
        CFG_DILATION     = 3'd4,
        CFG_PAD_WIDTH    = 3'd5,
        CFG_ACT_MODE     = 3'd6,
        CFG_LEAKY_SLOPE  = 3'd7
    } t_cfg_idx;

    // Activation functions.
    typedef enum logic [1:0] {
        ACTV_NONE  = 2'd0,
        ACTV_RELU  = 2'd1,
        ACTV_LEAKY = 2'd2,
        ACTV_RELU6 = 2'd3
    } t_act_mode;

    // Tag that travels with each tap from the sequencer to the MAC unit.
    typedef struct packed {
        logic vld;
        logic zero;
        logic last;
    } t_tap;

    // Configuration register reset values.
    localparam logic [4:0] RST_IN_CHANNELS  = 5'd1;
    localparam logic [4:0] RST_OUT_CHANNELS = 5'd1;
    localparam logic [4:0] RST_KERNEL_WIDTH = 5'd3;
    localparam logic [4:0] RST_STRIDE       = 5'd1;
    localparam logic [4:0] RST_DILATION     = 5'd1;
    localparam logic [3:0] RST_PAD_WIDTH    = 4'd0;
    localparam logic [1:0] RST_ACT_MODE     = 2'd0;
    localparam logic [7:0] RST_LEAKY_SLOPE  = 8'd26;

    // Upper limits of stride and dilation.
    localparam int STRIDE_MAX   = 16;
    localparam int DILATION_MAX = 16;

    // Width of the loaded length: holds one past the largest 9-bit position.
    localparam int LEN_W = 10;
    // Width of a tap's position in the padded input.
    localparam int T_W = 14;

    // 6.0 in Q8.8.
    localparam int RELU6_LIMIT = 1536;

    // Clamp a 5-bit register value into 1..hi.
    function automatic logic [4:0] sat_cfg(input logic [4:0] v, input int hi);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (32'(v) > hi) begin
            r = 5'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/conv1d_dilated_bias_activation.sv -----
// Top level: stores, configuration registers and tap sequencer of the convolution.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------------
//  input    | i_in_valid / o_in_stall  | i_action i_out_channel i_in_channel i_position
//           |                          | i_data_value
//  output   | o_out_valid / i_out_stall| o_result_value o_out_of_range
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index i_cfg_data
//
// A load request leaves the input open. A compute request reads the taps of every
// input channel in use, one tap a cycle through the single shared multiplier; an
// out-of-range compute issues no taps and gives a zero result. The input stalls while
// a compute runs and while its result waits behind a full output register. Reset is
// synchronous and clears the state, configuration registers, loaded length and bias
// valid flags; the weight, sample and bias stores are not cleared.
module conv1d_dilated_bias_activation #(
    parameter int MAX_IN_CHANNELS  = 16,
    parameter int MAX_OUT_CHANNELS = 16,
    parameter int MAX_KERNEL       = 16,
    parameter int MAX_LENGTH       = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [3:0]         i_out_channel,
    input  logic [3:0]         i_in_channel,
    input  logic [8:0]         i_position,
    input  logic signed [15:0] i_data_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_result_value,
    output logic               o_out_of_range,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    localparam int IC_W    = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int OC_W    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int KW_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL;
    localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int S_DEPTH = MAX_IN_CHANNELS * MAX_LENGTH;
    localparam int SA_W    = $clog2(S_DEPTH);
    localparam int OC_STEP = MAX_IN_CHANNELS * MAX_KERNEL;
    localparam int ACC_W   = 34 + $clog2(MAX_IN_CHANNELS * MAX_KERNEL);
    localparam int T_W     = cdba_pkg::T_W;
    localparam int LEN_W   = cdba_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_RUN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [4:0] r_cfg_in_ch;
    logic [4:0] r_cfg_out_ch;
    logic [4:0] r_cfg_kw;
    logic [4:0] r_cfg_stride;
    logic [4:0] r_cfg_dil;
    logic [3:0] r_cfg_pad;
    logic [1:0] r_cfg_act;
    logic [7:0] r_cfg_slope;

    // Stores.
    logic signed [15:0] r_wmem [W_DEPTH];
    logic signed [15:0] r_smem [S_DEPTH];
    logic signed [15:0] r_bmem [MAX_OUT_CHANNELS];
    logic [MAX_OUT_CHANNELS-1:0] r_bias_vld;
    logic [LEN_W-1:0]   r_len;

    // Sequencer registers.
    logic [3:0]         r_oc;
    logic [8:0]         r_pos;
    logic [T_W-1:0]     r_pst;
    logic [10:0]        r_ext;
    logic               r_oc_ok;
    logic [T_W-1:0]     r_t;
    logic [IC_W-1:0]    r_c;
    logic [KW_W-1:0]    r_k;
    logic [WA_W-1:0]    r_wbase;
    logic [SA_W-1:0]    r_sbase;
    logic               r_mac_start;
    logic               r_bias_ok;
    logic signed [15:0] r_bias;
    cdba_pkg::t_tap     r_tap;
    logic signed [15:0] r_wrd;
    logic signed [15:0] r_srd;
    logic signed [15:0] r_res_val;
    logic               r_res_oor;
    logic               r_out_vld;
    logic signed [15:0] r_out_val;
    logic               r_out_oor;

    // Combinational helpers.
    logic               n_in_acc;
    logic [4:0]         n_nic;
    logic [4:0]         n_noc;
    logic [4:0]         n_kw;
    logic [4:0]         n_st;
    logic [4:0]         n_dl;
    logic               n_w_ok;
    logic               n_b_ok;
    logic               n_s_ok;
    logic [WA_W-1:0]    n_w_ld_addr;
    logic [SA_W-1:0]    n_s_ld_addr;
    logic [10:0]        n_padded;
    logic               n_in_range;
    logic [T_W-1:0]     n_idx;
    logic               n_s_in;
    logic [WA_W-1:0]    n_w_rd_addr;
    logic [SA_W-1:0]    n_s_rd_addr;
    logic               n_k_last;
    logic               n_c_last;
    logic               n_mac_done;
    logic signed [15:0] n_mac_val;
    logic signed [15:0] n_mac_bias;

    // Effective register values, clamped to the supported range.
    always_comb begin
        n_nic = cdba_pkg::sat_cfg(r_cfg_in_ch, MAX_IN_CHANNELS);
        n_noc = cdba_pkg::sat_cfg(r_cfg_out_ch, MAX_OUT_CHANNELS);
        n_kw  = cdba_pkg::sat_cfg(r_cfg_kw, MAX_KERNEL);
        n_st  = cdba_pkg::sat_cfg(r_cfg_stride, cdba_pkg::STRIDE_MAX);
        n_dl  = cdba_pkg::sat_cfg(r_cfg_dil, cdba_pkg::DILATION_MAX);
    end

    // Load addressing and bounds checks.
    always_comb begin
        n_in_acc = i_in_valid && !o_in_stall;
        n_w_ok = (32'(i_out_channel) < MAX_OUT_CHANNELS) &&
                 (32'(i_in_channel) < MAX_IN_CHANNELS) &&
                 (32'(i_position) < MAX_KERNEL);
        n_b_ok = 32'(i_out_channel) < MAX_OUT_CHANNELS;
        n_s_ok = (32'(i_in_channel) < MAX_IN_CHANNELS) &&
                 (32'(i_position) < MAX_LENGTH);
        n_w_ld_addr = WA_W'((32'(i_out_channel) * MAX_IN_CHANNELS + 32'(i_in_channel))
                            * MAX_KERNEL + 32'(i_position));
        n_s_ld_addr = SA_W'(32'(i_in_channel) * MAX_LENGTH + 32'(i_position));
    end

    // Output length check and tap addressing.
    always_comb begin
        n_padded   = 11'(r_len) + 11'({r_cfg_pad, 1'b0});
        // Position j is valid when j*stride + extent fits in the padded input.
        n_in_range = r_oc_ok && ((15'(r_pst) + 15'(r_ext)) <= 15'(n_padded));
        n_idx      = r_t - T_W'(r_cfg_pad);
        n_s_in     = (r_t >= T_W'(r_cfg_pad)) && (n_idx < T_W'(r_len));
        n_w_rd_addr = r_wbase + WA_W'(r_k);
        n_s_rd_addr = r_sbase + SA_W'(n_idx);
        n_k_last   = 32'(r_k) == (32'(n_kw) - 1);
        n_c_last   = 32'(r_c) == (32'(n_nic) - 1);
        n_mac_bias = r_bias_ok ? r_bias : 16'sd0;
    end

    // Weight, sample and bias stores.
    always_ff @(posedge i_clk) begin
        if (n_in_acc && (cdba_pkg::t_action'(i_action) == cdba_pkg::ACT_LOAD_WEIGHT)
            && n_w_ok) begin
            r_wmem[n_w_ld_addr] <= i_data_value;
        end
        if (n_in_acc && (cdba_pkg::t_action'(i_action) == cdba_pkg::ACT_LOAD_SAMPLE)
            && n_s_ok) begin
            r_smem[n_s_ld_addr] <= i_data_value;
        end
        if (n_in_acc && (cdba_pkg::t_action'(i_action) == cdba_pkg::ACT_LOAD_BIAS)
            && n_b_ok) begin
            r_bmem[OC_W'(i_out_channel)] <= i_data_value;
        end
        r_wrd  <= r_wmem[n_w_rd_addr];
        r_srd  <= r_smem[n_s_rd_addr];
        r_bias <= r_bmem[OC_W'(r_oc)];
    end

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_in_ch  <= cdba_pkg::RST_IN_CHANNELS;
            r_cfg_out_ch <= cdba_pkg::RST_OUT_CHANNELS;
            r_cfg_kw     <= cdba_pkg::RST_KERNEL_WIDTH;
            r_cfg_stride <= cdba_pkg::RST_STRIDE;
            r_cfg_dil    <= cdba_pkg::RST_DILATION;
            r_cfg_pad    <= cdba_pkg::RST_PAD_WIDTH;
            r_cfg_act    <= cdba_pkg::RST_ACT_MODE;
            r_cfg_slope  <= cdba_pkg::RST_LEAKY_SLOPE;
            r_bias_vld   <= '0;
            r_len        <= '0;
            r_tap        <= '0;
            r_mac_start  <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_tap       <= '0;
            r_mac_start <= 1'b0;

            // Register writes.
            if (i_cfg_valid) begin
                case (cdba_pkg::t_cfg_idx'(i_cfg_index))
                    cdba_pkg::CFG_IN_CHANNELS:  r_cfg_in_ch  <= i_cfg_data[4:0];
                    cdba_pkg::CFG_OUT_CHANNELS: r_cfg_out_ch <= i_cfg_data[4:0];
                    cdba_pkg::CFG_KERNEL_WIDTH: r_cfg_kw     <= i_cfg_data[4:0];
                    cdba_pkg::CFG_STRIDE:       r_cfg_stride <= i_cfg_data[4:0];
                    cdba_pkg::CFG_DILATION:     r_cfg_dil    <= i_cfg_data[4:0];
                    cdba_pkg::CFG_PAD_WIDTH:    r_cfg_pad    <= i_cfg_data[3:0];
                    cdba_pkg::CFG_ACT_MODE:     r_cfg_act    <= i_cfg_data[1:0];
                    cdba_pkg::CFG_LEAKY_SLOPE:  r_cfg_slope  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // The output register empties when its result is taken.
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        case (cdba_pkg::t_action'(i_action))
                            cdba_pkg::ACT_LOAD_BIAS: begin
                                if (n_b_ok) begin
                                    r_bias_vld[OC_W'(i_out_channel)] <= 1'b1;
                                end
                            end
                            cdba_pkg::ACT_LOAD_SAMPLE: begin
                                if (n_s_ok && ((LEN_W'(i_position) + 1'b1) > r_len)) begin
                                    r_len <= LEN_W'(i_position) + 1'b1;
                                end
                            end
                            cdba_pkg::ACT_COMPUTE: begin
                                r_oc    <= i_out_channel;
                                r_pos   <= i_position;
                                r_state <= S_PREP;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    r_pst     <= T_W'(r_pos) * T_W'(n_st);
                    r_ext     <= 11'(n_dl) * 11'(n_kw - 5'd1) + 11'd1;
                    r_oc_ok   <= 5'(r_oc) < n_noc;
                    r_bias_ok <= r_bias_vld[OC_W'(r_oc)];
                    r_wbase   <= WA_W'(32'(r_oc) * OC_STEP);
                    r_sbase   <= '0;
                    r_c       <= '0;
                    r_k       <= '0;
                    r_state   <= S_CHECK;
                end
                S_CHECK: begin
                    r_t         <= r_pst;
                    r_mac_start <= 1'b1;
                    if (n_in_range) begin
                        r_state <= S_RUN;
                    end else begin
                        r_res_val <= 16'sd0;
                        r_res_oor <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_RUN: begin
                    // Issue one tap a cycle; stores answer on the next edge.
                    r_tap.vld  <= 1'b1;
                    r_tap.zero <= !n_s_in;
                    r_tap.last <= n_k_last && n_c_last;
                    if (n_k_last) begin
                        r_k     <= '0;
                        r_t     <= r_pst;
                        r_c     <= r_c + 1'b1;
                        r_wbase <= r_wbase + WA_W'(MAX_KERNEL);
                        r_sbase <= r_sbase + SA_W'(MAX_LENGTH);
                        if (n_c_last) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_t <= r_t + T_W'(n_dl);
                    end
                end
                S_DRAIN: begin
                    if (n_mac_done) begin
                        r_res_val <= n_mac_val;
                        r_res_oor <= 1'b0;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld <= 1'b1;
                        r_out_val <= r_res_val;
                        r_out_oor <= r_res_oor;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Shared multiply-accumulate unit.
    cdba_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mac_start),
        .i_bias   (n_mac_bias),
        .i_tap    (r_tap),
        .i_sample (r_srd),
        .i_weight (r_wrd),
        .i_mode   (cdba_pkg::t_act_mode'(r_cfg_act)),
        .i_slope  (r_cfg_slope),
        .o_done   (n_mac_done),
        .o_value  (n_mac_val)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_out_val;
    assign o_out_of_range = r_out_oor;

endmodule

// ----- rtl/core/cdba_mac.sv -----
// Shared multiply-accumulate unit with rounding, activation and saturation.
module cdba_mac #(
    parameter int ACC_W = 42
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [15:0]       i_bias,
    input  cdba_pkg::t_tap           i_tap,
    input  logic signed [15:0]       i_sample,
    input  logic signed [15:0]       i_weight,
    input  cdba_pkg::t_act_mode      i_mode,
    input  logic [7:0]               i_slope,
    output logic                     o_done,
    output logic signed [15:0]       o_value
);

    localparam int V_W  = ACC_W - 7;
    localparam int LK_W = 26;
    localparam int LP_W = LK_W + 9;
    localparam int FW   = (V_W > LP_W) ? V_W : LP_W;

    localparam logic signed [V_W-1:0] LK_MIN    = V_W'(-(64'sd1 <<< 24));
    localparam logic signed [V_W-1:0] RELU6_MAX = V_W'(cdba_pkg::RELU6_LIMIT);
    localparam logic signed [FW-1:0]  SAT_MAX   = FW'(32767);
    localparam logic signed [FW-1:0]  SAT_MIN   = FW'(-32768);

    logic                    r_p_vld;
    logic                    r_p_last;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_sum_vld;
    logic                    r_r_vld;
    logic signed [V_W-1:0]   r_v;
    logic                    r_a_vld;
    logic                    r_a_lk;
    logic signed [V_W-1:0]   r_a_val;
    logic signed [LP_W-1:0]  r_lk_prod;
    logic                    r_done;
    logic signed [15:0]      r_value;

    logic signed [ACC_W:0]   n_rnd;
    logic                    n_neg;
    logic signed [V_W-1:0]   n_act;
    logic signed [LK_W-1:0]  n_lkv;
    logic signed [LP_W-1:0]  n_lk_rnd;
    logic signed [FW-1:0]    n_src;
    logic signed [15:0]      n_sat;

    // Rounding of the accumulator to Q8.8 and activation selection.
    always_comb begin
        n_rnd = $signed({r_acc[ACC_W-1], r_acc}) + (ACC_W+1)'(128);
        n_neg = r_v[V_W-1];
        n_act = r_v;
        case (i_mode)
            cdba_pkg::ACTV_NONE: begin
                n_act = r_v;
            end
            cdba_pkg::ACTV_RELU: begin
                n_act = n_neg ? '0 : r_v;
            end
            cdba_pkg::ACTV_LEAKY: begin
                n_act = r_v;
            end
            cdba_pkg::ACTV_RELU6: begin
                if (n_neg) begin
                    n_act = '0;
                end else if (r_v > RELU6_MAX) begin
                    n_act = RELU6_MAX;
                end else begin
                    n_act = r_v;
                end
            end
            default: begin
                n_act = r_v;
            end
        endcase
        // Below -2^24 the leaky result saturates for any nonzero slope.
        n_lkv = (r_v < LK_MIN) ? LK_W'(LK_MIN) : LK_W'(r_v);
    end

    // Final leaky rounding and saturation to 16 bits.
    always_comb begin
        n_lk_rnd = (r_lk_prod + LP_W'(128)) >>> 8;
        n_src    = r_a_lk ? FW'(n_lk_rnd) : FW'(r_a_val);
        if (n_src > SAT_MAX) begin
            n_sat = 16'sh7fff;
        end else if (n_src < SAT_MIN) begin
            n_sat = -16'sh8000;
        end else begin
            n_sat = 16'(n_src);
        end
    end

    // Product, accumulator and post-processing stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_p_last  <= 1'b0;
            r_sum_vld <= 1'b0;
            r_r_vld   <= 1'b0;
            r_a_vld   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_p_vld   <= i_tap.vld;
            r_p_last  <= i_tap.vld & i_tap.last;
            r_sum_vld <= r_p_last;
            r_r_vld   <= r_sum_vld;
            r_a_vld   <= r_r_vld;
            r_done    <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // Padding taps contribute nothing, whatever the stores hold.
        if (i_tap.vld) begin
            r_prod <= i_tap.zero ? 32'sd0 : i_sample * i_weight;
        end
        if (i_start) begin
            r_acc <= {{(ACC_W-24){i_bias[15]}}, i_bias, 8'h00};
        end else if (r_p_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_sum_vld) begin
            r_v <= $signed(n_rnd[ACC_W:8]);
        end
        if (r_r_vld) begin
            r_a_val   <= n_act;
            r_a_lk    <= (i_mode == cdba_pkg::ACTV_LEAKY) && n_neg;
            r_lk_prod <= n_lkv * $signed({1'b0, i_slope});
        end
        if (r_a_vld) begin
            r_value <= n_sat;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

// ----- rtl/core/cdba_checker.sv -----
// Port-level checks of the convolution block and their binding to the top level.
module cdba_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [1:0]         i_action,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_result_value,
    input logic               o_out_of_range
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_value)
                                          && $stable(o_out_of_range)))
        else $error("stalled result changed");

    // A load request completes in its cycle; the input is open again next cycle.
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action != cdba_pkg::ACT_COMPUTE))
        |=> !o_in_stall)
        else $error("load request kept the input stalled");

    // A compute request keeps the block busy.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == cdba_pkg::ACT_COMPUTE))
        |=> o_in_stall)
        else $error("compute request did not stall the input");

    // An out-of-range result carries a zero value.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_result_value == 16'sd0))
        else $error("out-of-range result with nonzero value");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind conv1d_dilated_bias_activation cdba_checker u_cdba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_action       (i_action),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value),
    .o_out_of_range (o_out_of_range)
);

// ----- tb/sv/conv1d_dilated_bias_activation_tb.sv -----
// Self-checking testbench for the dilated 1D convolution block with bias and activation.
module conv1d_dilated_bias_activation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS      = 16;
    localparam int TAPS          = 16;
    localparam int SAMPLES       = 256;
    localparam int SETTLE_CYCLES = 32;

    // One computed output as it leaves the block.
    typedef struct packed {
        logic signed [15:0] value;
        logic               out_of_range;
    } t_conv_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_action = cdba_pkg::ACT_LOAD_WEIGHT;
    logic [3:0]         i_out_channel = '0;
    logic [3:0]         i_in_channel = '0;
    logic [8:0]         i_position = '0;
    logic signed [15:0] i_data_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_result_value;
    logic               o_out_of_range;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = cdba_pkg::CFG_IN_CHANNELS;
    logic [7:0]         i_cfg_data = '0;

    conv1d_dilated_bias_activation uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_out_channel  (i_out_channel),
        .i_in_channel   (i_in_channel),
        .i_position     (i_position),
        .i_data_value   (i_data_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_out_of_range (o_out_of_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the block's stores and register file.
    shortint weight_mem [CHANNELS][CHANNELS][TAPS];
    bit      weight_set [CHANNELS][CHANNELS][TAPS];
    shortint bias_mem   [CHANNELS];
    shortint sample_mem [CHANNELS][SAMPLES];
    bit      sample_set [CHANNELS][SAMPLES];
    int      loaded_len = 0;

    logic [4:0] reg_in_channels  = cdba_pkg::RST_IN_CHANNELS;
    logic [4:0] reg_out_channels = cdba_pkg::RST_OUT_CHANNELS;
    logic [4:0] reg_kernel_width = cdba_pkg::RST_KERNEL_WIDTH;
    logic [4:0] reg_stride       = cdba_pkg::RST_STRIDE;
    logic [4:0] reg_dilation     = cdba_pkg::RST_DILATION;
    logic [3:0] reg_pad_width    = cdba_pkg::RST_PAD_WIDTH;
    logic [1:0] reg_act_mode     = cdba_pkg::RST_ACT_MODE;
    logic [7:0] reg_leaky_slope  = cdba_pkg::RST_LEAKY_SLOPE;

    // Register values as the datapath uses them.
    int eff_nic, eff_noc, eff_kw, eff_st, eff_dl;

    t_conv_result pending_results[$];
    int           error_count = 0;
    bit           idling_on = 1'b1;

    function automatic int clamp_setting(input logic [4:0] v, input int hi);
        if (v == 5'd0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic void refresh_geometry();
        eff_nic = clamp_setting(reg_in_channels, CHANNELS);
        eff_noc = clamp_setting(reg_out_channels, CHANNELS);
        eff_kw  = clamp_setting(reg_kernel_width, TAPS);
        eff_st  = clamp_setting(reg_stride, cdba_pkg::STRIDE_MAX);
        eff_dl  = clamp_setting(reg_dilation, cdba_pkg::DILATION_MAX);
    endfunction

    // Number of valid output positions for the current length and geometry.
    function automatic int output_width();
        int padded;
        int extent;
        padded = loaded_len + 2 * int'(reg_pad_width);
        extent = eff_dl * (eff_kw - 1) + 1;
        if (padded < extent) return 0;
        return (padded - extent) / eff_st + 1;
    endfunction

    // Bias plus multiply-accumulate over channels and taps, then rounding,
    // activation and saturation.
    function automatic t_conv_result predict_output(input int oc, input int pos);
        t_conv_result r;
        longint acc;
        longint v;
        longint smp;
        int t;
        r.value = '0;
        r.out_of_range = 1'b1;
        if (oc >= eff_noc || pos >= output_width()) return r;
        acc = longint'(bias_mem[oc]) * 256;
        for (int c = 0; c < eff_nic; c++) begin
            for (int k = 0; k < eff_kw; k++) begin
                t = pos * eff_st + k * eff_dl - int'(reg_pad_width);
                smp = 0;
                if (t >= 0 && t < loaded_len) smp = longint'(sample_mem[c][t]);
                acc += smp * longint'(weight_mem[oc][c][k]);
            end
        end
        v = (acc + 128) >>> 8;
        case (cdba_pkg::t_act_mode'(reg_act_mode))
            cdba_pkg::ACTV_RELU: begin
                if (v < 0) v = 0;
            end
            cdba_pkg::ACTV_LEAKY: begin
                if (v < 0) v = (v * longint'(reg_leaky_slope) + 128) >>> 8;
            end
            cdba_pkg::ACTV_RELU6: begin
                if (v < 0) v = 0;
                if (v > cdba_pkg::RELU6_LIMIT) v = cdba_pkg::RELU6_LIMIT;
            end
            default: ;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.value = 16'(v);
        r.out_of_range = 1'b0;
        return r;
    endfunction

    // Apply one accepted request to the shadow state.
    function automatic void record_request(input cdba_pkg::t_action act, input int oc,
                                           input int ic, input int pos,
                                           input logic signed [15:0] dv);
        case (act)
            cdba_pkg::ACT_LOAD_WEIGHT: begin
                if (pos < TAPS) begin
                    weight_mem[oc][ic][pos] = dv;
                    weight_set[oc][ic][pos] = 1'b1;
                end
            end
            cdba_pkg::ACT_LOAD_BIAS: begin
                bias_mem[oc] = dv;
            end
            cdba_pkg::ACT_LOAD_SAMPLE: begin
                if (pos < SAMPLES) begin
                    sample_mem[ic][pos] = dv;
                    sample_set[ic][pos] = 1'b1;
                    if (pos + 1 > loaded_len) loaded_len = pos + 1;
                end
            end
            cdba_pkg::ACT_COMPUTE: begin
                pending_results.push_back(predict_output(oc, pos));
            end
            default: ;
        endcase
    endfunction

    // Mostly small Q8.8 values, sometimes any 16-bit pattern.
    function automatic logic signed [15:0] random_q88();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 1023)) - 512);
    endfunction

    // Present one request, with an optional random gap, and wait until it is taken.
    task automatic send_request(input cdba_pkg::t_action act, input int oc, input int ic,
                                input int pos, input logic signed [15:0] dv);
        int gap;
        gap = 0;
        oc = oc & 15;
        ic = ic & 15;
        pos = pos & 511;
        if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_out_channel <= 4'(oc);
        i_in_channel  <= 4'(ic);
        i_position    <= 9'(pos);
        i_data_value  <= dv;
        do @(posedge i_clk); while (o_in_stall);
        record_request(act, oc, ic, pos, dv);
    endtask

    // Hold off new requests until every expected result is back, then let the
    // last load settle.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input cdba_pkg::t_cfg_idx idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            cdba_pkg::CFG_IN_CHANNELS:  reg_in_channels  = data[4:0];
            cdba_pkg::CFG_OUT_CHANNELS: reg_out_channels = data[4:0];
            cdba_pkg::CFG_KERNEL_WIDTH: reg_kernel_width = data[4:0];
            cdba_pkg::CFG_STRIDE:       reg_stride       = data[4:0];
            cdba_pkg::CFG_DILATION:     reg_dilation     = data[4:0];
            cdba_pkg::CFG_PAD_WIDTH:    reg_pad_width    = data[3:0];
            cdba_pkg::CFG_ACT_MODE:     reg_act_mode     = data[1:0];
            cdba_pkg::CFG_LEAKY_SLOPE:  reg_leaky_slope  = data;
            default: ;
        endcase
    endtask

    // Write the whole register file; valid stays high across the writes.
    task automatic apply_settings(input logic [7:0] nic, input logic [7:0] noc,
                                  input logic [7:0] kw, input logic [7:0] st,
                                  input logic [7:0] dl, input logic [7:0] pad,
                                  input cdba_pkg::t_act_mode mode, input logic [7:0] slope);
        write_register(cdba_pkg::CFG_IN_CHANNELS, nic);
        write_register(cdba_pkg::CFG_OUT_CHANNELS, noc);
        write_register(cdba_pkg::CFG_KERNEL_WIDTH, kw);
        write_register(cdba_pkg::CFG_STRIDE, st);
        write_register(cdba_pkg::CFG_DILATION, dl);
        write_register(cdba_pkg::CFG_PAD_WIDTH, pad);
        write_register(cdba_pkg::CFG_ACT_MODE, 8'(mode));
        write_register(cdba_pkg::CFG_LEAKY_SLOPE, slope);
        i_cfg_valid <= 1'b0;
        refresh_geometry();
    endtask

    // Load every weight and sample a compute will read that has not been written yet.
    task automatic fill_operands(input int oc, input int pos);
        int t;
        if (oc >= eff_noc || pos >= output_width()) return;
        for (int c = 0; c < eff_nic; c++) begin
            for (int k = 0; k < eff_kw; k++) begin
                if (!weight_set[oc][c][k])
                    send_request(cdba_pkg::ACT_LOAD_WEIGHT, oc, c, k, random_q88());
                t = pos * eff_st + k * eff_dl - int'(reg_pad_width);
                if (t >= 0 && t < loaded_len && !sample_set[c][t])
                    send_request(cdba_pkg::ACT_LOAD_SAMPLE, 0, c, t, random_q88());
            end
        end
    endtask

    // Random mix of loads and computes; computes have their operands loaded first.
    task automatic run_random_requests(input int count);
        int sel;
        int oc;
        int ic;
        int pos;
        int width;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            oc  = $urandom_range(0, 15);
            ic  = $urandom_range(0, 15);
            if (sel < 40) begin
                if ($urandom_range(0, 7) != 0) oc = $urandom_range(0, eff_noc - 1);
                width = output_width();
                if (width > 0 && $urandom_range(0, 9) != 0) pos = $urandom_range(0, width - 1);
                else pos = $urandom_range(0, 511);
                fill_operands(oc, pos);
                send_request(cdba_pkg::ACT_COMPUTE, oc, ic, pos, random_q88());
            end else if (sel < 60) begin
                pos = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 511);
                send_request(cdba_pkg::ACT_LOAD_WEIGHT, oc, ic, pos, random_q88());
            end else if (sel < 70) begin
                send_request(cdba_pkg::ACT_LOAD_BIAS, oc, ic, $urandom_range(0, 511),
                             random_q88());
            end else begin
                if ($urandom_range(0, 4) != 0) ic = $urandom_range(0, eff_nic - 1);
                pos = ($urandom_range(0, 19) != 0) ? $urandom_range(0, 63) : $urandom_range(0, 511);
                send_request(cdba_pkg::ACT_LOAD_SAMPLE, oc, ic, pos, random_q88());
            end
            if ($urandom_range(0, 59) == 0) wait_for_results();
        end
    endtask

    // Reset defaults: empty input, extreme values, ignored loads, positions past
    // the output and an output channel not in use.
    task automatic test_directed_loads_and_edges();
        send_request(cdba_pkg::ACT_COMPUTE, 0, 0, 0, '0);
        send_request(cdba_pkg::ACT_LOAD_SAMPLE, 0, 0, 0, 16'sh7fff);
        send_request(cdba_pkg::ACT_LOAD_SAMPLE, 0, 0, 1, 16'sh8000);
        send_request(cdba_pkg::ACT_LOAD_SAMPLE, 0, 0, 2, 16'sh0100);
        send_request(cdba_pkg::ACT_LOAD_SAMPLE, 0, 0, 3, -16'sh0100);
        send_request(cdba_pkg::ACT_LOAD_SAMPLE, 0, 0, 4, 16'sh1234);
        send_request(cdba_pkg::ACT_LOAD_SAMPLE, 15, 15, 511, 16'sh5555);
        send_request(cdba_pkg::ACT_LOAD_SAMPLE, 15, 15, 256, -16'sh5556);
        send_request(cdba_pkg::ACT_LOAD_WEIGHT, 0, 0, 0, 16'sh7fff);
        send_request(cdba_pkg::ACT_LOAD_WEIGHT, 0, 0, 1, 16'sh8000);
        send_request(cdba_pkg::ACT_LOAD_WEIGHT, 0, 0, 2, 16'sh0100);
        send_request(cdba_pkg::ACT_LOAD_WEIGHT, 15, 15, 16, 16'sh2222);
        send_request(cdba_pkg::ACT_LOAD_WEIGHT, 15, 15, 511, 16'sh3333);
        send_request(cdba_pkg::ACT_LOAD_BIAS, 15, 15, 511, 16'sh7fff);
        send_request(cdba_pkg::ACT_LOAD_BIAS, 0, 0, 0, 16'sh8000);
        send_request(cdba_pkg::ACT_COMPUTE, 0, 0, 0, '0);
        send_request(cdba_pkg::ACT_COMPUTE, 0, 15, 1, '0);
        send_request(cdba_pkg::ACT_COMPUTE, 0, 0, 2, '0);
        send_request(cdba_pkg::ACT_COMPUTE, 0, 0, 3, '0);
        send_request(cdba_pkg::ACT_COMPUTE, 0, 0, 511, 16'shffff);
        send_request(cdba_pkg::ACT_COMPUTE, 1, 0, 0, '0);
        wait_for_results();
    endtask

    // Several ordinary geometries, one per activation function.
    task automatic test_random_settings();
        apply_settings(8'd2, 8'd4, 8'd3, 8'd1, 8'd1, 8'd1, cdba_pkg::ACTV_RELU, 8'd26);
        run_random_requests(25);
        wait_for_results();
        apply_settings(8'd3, 8'd2, 8'd5, 8'd2, 8'd2, 8'd3, cdba_pkg::ACTV_LEAKY, 8'd0);
        run_random_requests(25);
        wait_for_results();
        apply_settings(8'd1, 8'd16, 8'd1, 8'd3, 8'd1, 8'd0, cdba_pkg::ACTV_NONE, 8'd128);
        run_random_requests(25);
        wait_for_results();
        apply_settings(8'd4, 8'd3, 8'd4, 8'd1, 8'd3, 8'd2, cdba_pkg::ACTV_RELU6, 8'd64);
        run_random_requests(25);
        wait_for_results();
    endtask

    // Register values of zero and past the limits are clamped at use.
    task automatic test_register_saturation();
        apply_settings(8'd0, 8'd255, 8'd31, 8'd0, 8'd31, 8'd15, cdba_pkg::ACTV_NONE, 8'd1);
        run_random_requests(10);
        wait_for_results();
        apply_settings(8'd31, 8'd0, 8'd0, 8'd31, 8'd0, 8'd0, cdba_pkg::ACTV_RELU6, 8'd2);
        run_random_requests(10);
        wait_for_results();
    endtask

    // Largest output channel count, kernel, stride, dilation and padding over a
    // full input.
    task automatic test_extreme_geometry();
        apply_settings(8'd2, 8'd16, 8'd16, 8'd16, 8'd16, 8'd15, cdba_pkg::ACTV_LEAKY, 8'd255);
        send_request(cdba_pkg::ACT_LOAD_SAMPLE, 0, 0, SAMPLES - 1, random_q88());
        run_random_requests(6);
        wait_for_results();
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_unstalled_tail();
        idling_on = 1'b0;
        apply_settings(8'd2, 8'd2, 8'd3, 8'd1, 8'd2, 8'd1, cdba_pkg::ACTV_LEAKY, 8'd77);
        run_random_requests(40);
        wait_for_results();
    endtask

    // Receiver back-pressure in random bursts, with open stretches in between.
    int hold_cycles = 0;
    bit hold_stalled = 1'b0;
    always @(posedge i_clk) begin
        if (hold_cycles == 0) begin
            hold_stalled = !hold_stalled;
            hold_cycles = hold_stalled ? $urandom_range(1, 14) : $urandom_range(1, 30);
        end
        hold_cycles--;
        i_out_stall <= idling_on && hold_stalled;
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_conv_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual value %0d flag %0b",
                         $time, o_result_value, o_out_of_range);
            end else begin
                want = pending_results.pop_front();
                if (o_result_value !== want.value) begin
                    error_count++;
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, want.value, o_result_value);
                end
                if (o_out_of_range !== want.out_of_range) begin
                    error_count++;
                    $display("%0t: out_of_range expected %0b actual %0b",
                             $time, want.out_of_range, o_out_of_range);
                end
            end
        end
    end

    initial begin
        refresh_geometry();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_loads_and_edges();
        test_random_settings();
        test_register_saturation();
        test_extreme_geometry();
        test_unstalled_tail();
        wait_for_results();
        if (error_count == 0) begin
            $display("conv1d_dilated_bias_activation_tb: clean");
        end else begin
            $display("conv1d_dilated_bias_activation_tb: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #50ms;
        $display("conv1d_dilated_bias_activation_tb: errors");
        $finish;
    end

endmodule

// ----- conv1d_dilated_bias_activation.f -----
rtl/core/cdba_pkg.sv
rtl/core/cdba_mac.sv
rtl/core/conv1d_dilated_bias_activation.sv
rtl/core/cdba_checker.sv
tb/sv/conv1d_dilated_bias_activation_tb.sv
